FILE: rtl/core/bptm_pkg.sv
package bptm_pkg;

    localparam int unsigned SCREEN_COLUMNS_DEFAULT  = 128;
    localparam int unsigned SCREEN_ROWS_DEFAULT     = 64;
    localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    localparam logic [1:0] DEPTH_MONO   = 2'd0;
    localparam logic [1:0] DEPTH_INDEX8 = 2'd1;
    localparam logic [1:0] DEPTH_BGR24  = 2'd2;

    localparam logic [2:0] REG_DEPTH     = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_BOTTOM_UP = 3'd3;
    localparam logic [2:0] REG_FLIP      = 3'd4;
    localparam logic [2:0] REG_THRESHOLD = 3'd5;

    localparam logic [1:0]  DEPTH_RESET     = DEPTH_MONO;
    localparam logic [11:0] WIDTH_RESET     = 12'd128;
    localparam logic [11:0] HEIGHT_RESET    = 12'd64;
    localparam logic        BOTTOM_UP_RESET = 1'b1;
    localparam logic        FLIP_RESET      = 1'b0;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd128;

    typedef struct packed {
        logic [1:0]  depth;
        logic [11:0] width;
        logic [11:0] height;
        logic        bottom_up;
        logic        flip;
        logic [7:0]  threshold;
    } cfg_t;

    typedef struct packed {
        logic [7:0] lit;
        logic [7:0] mask;
        logic [6:0] base;
        logic [5:0] row;
    } job_t;

endpackage

FILE: rtl/core/bptm_front.sv
module bptm_front #(
    parameter int unsigned SCREEN_COLUMNS  = bptm_pkg::SCREEN_COLUMNS_DEFAULT,
    parameter int unsigned SCREEN_ROWS     = bptm_pkg::SCREEN_ROWS_DEFAULT,
    parameter int unsigned PALETTE_ENTRIES = bptm_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bptm_pkg::cfg_t   cfg,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic             operation,
    input  logic [7:0]       palette_index,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [7:0]       data_byte,
    output bptm_pkg::job_t   job,
    output logic             job_push,
    input  logic             queue_full
);
    import bptm_pkg::*;

    localparam int unsigned AW = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [17:0] LUMA_R = 18'd299;
    localparam logic [17:0] LUMA_G = 18'd587;
    localparam logic [17:0] LUMA_B = 18'd114;
    localparam int unsigned LUMA_SHIFT = 28;
    localparam logic [36:0] LUMA_RECIP = 37'd268436;
    localparam logic [11:0] ROW_LIMIT = 12'(SCREEN_ROWS);
    localparam logic [16:0] COL_LIMIT = 17'(SCREEN_COLUMNS);
    localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_MONO    = 2'd1,
        KIND_INDEX   = 2'd2,
        KIND_COLOR   = 2'd3
    } kind_t;

    logic [13:0] pos_reg;
    logic [11:0] srow_reg;
    logic [15:0] held_reg;
    logic [1:0]  phase_reg;
    logic [11:0] col3_reg;

    logic        s0_valid_reg;
    kind_t       s0_kind_reg;
    logic [17:0] s0_sum_reg;
    logic [7:0]  s0_index_reg;
    logic [7:0]  s0_mask_reg;
    logic [6:0]  s0_base_reg;
    logic [5:0]  s0_row_reg;

    logic        s1_valid_reg;
    kind_t       s1_kind_reg;
    logic [7:0]  s1_luma_reg;
    logic [7:0]  s1_index_reg;
    logic [7:0]  s1_mask_reg;
    logic [6:0]  s1_base_reg;
    logic [5:0]  s1_row_reg;

    logic        s2_valid_reg;
    kind_t       s2_kind_reg;
    logic [7:0]  s2_luma_reg;
    logic [7:0]  s2_rd_reg;
    logic        s2_in_range_reg;
    logic [7:0]  s2_index_reg;
    logic [7:0]  s2_mask_reg;
    logic [6:0]  s2_base_reg;
    logic [5:0]  s2_row_reg;

    logic [7:0]  luma_mem [PALETTE_ENTRIES];
    logic [7:0]  luma0_reg;
    logic [7:0]  luma1_reg;

    logic        adv;
    logic        accept;
    logic        is_pixel;
    logic        is_color;
    logic [12:0] w_pad1;
    logic [12:0] w_pad8;
    logic [16:0] w24;
    logic [16:0] w_pad24;
    logic [14:0] row_size;
    logic [14:0] pos_inc;
    logic        row_end;
    logic [12:0] srow_inc;
    logic        srow_wrap;
    logic        row_in;
    logic [11:0] r_row;
    logic [11:0] d_row;
    logic        row_ok;
    logic [16:0] mono_base;
    logic [16:0] col_k;
    logic [7:0]  mono_mask;
    logic        idx_ok;
    logic        col3_ok;
    kind_t       kind;
    logic [7:0]  mask;
    logic [6:0]  base;
    logic [7:0]  r_op;
    logic [7:0]  g_op;
    logic [7:0]  b_op;
    logic [17:0] sum;
    logic [36:0] prod;
    logic        s1_in_range;
    logic [AW-1:0] s1_addr;
    logic        lit0;
    logic        lit1;
    logic [7:0]  idx_luma;
    logic        need;

    assign need       = s2_valid_reg && (s2_kind_reg != KIND_PALETTE) && (s2_mask_reg != 8'd0);
    assign adv        = !(need && queue_full);
    assign item_ready = adv;
    assign accept     = item_valid && item_ready;
    assign is_pixel   = (operation == OP_PIXEL);
    assign is_color   = (cfg.depth != DEPTH_MONO) && (cfg.depth != DEPTH_INDEX8);

    always_comb
    begin
        w_pad1  = {1'b0, cfg.width} + 13'd31;
        w_pad8  = {1'b0, cfg.width} + 13'd3;
        w24     = ({5'd0, cfg.width} << 4) + ({5'd0, cfg.width} << 3);
        w_pad24 = w24 + 17'd31;
        unique case (cfg.depth)
            DEPTH_MONO:   row_size = {5'd0, w_pad1[12:5], 2'b00};
            DEPTH_INDEX8: row_size = {2'd0, w_pad8[12:2], 2'b00};
            default:      row_size = {1'b0, w_pad24[16:5], 2'b00};
        endcase
    end

    assign pos_inc   = {1'b0, pos_reg} + 15'd1;
    assign row_end   = (pos_inc >= row_size);
    assign srow_inc  = {1'b0, srow_reg} + 13'd1;
    assign srow_wrap = (srow_inc >= {1'b0, cfg.height});

    always_comb
    begin
        row_in = (srow_reg < cfg.height);
        r_row  = cfg.bottom_up ? (cfg.height - 12'd1 - srow_reg) : srow_reg;
        d_row  = cfg.flip ? (cfg.height - 12'd1 - r_row) : r_row;
        row_ok = row_in && (r_row < ROW_LIMIT) && (d_row < ROW_LIMIT);
    end

    always_comb
    begin
        mono_base = {pos_reg, 3'b000};
        col_k     = mono_base;
        for (int k = 0; k < 8; k++)
        begin
            col_k        = mono_base + 17'(k);
            mono_mask[k] = (col_k < {5'd0, cfg.width}) && (col_k < COL_LIMIT);
        end
        idx_ok  = (pos_reg < {2'd0, cfg.width}) && ({3'd0, pos_reg} < COL_LIMIT);
        col3_ok = (col3_reg < cfg.width) && ({5'd0, col3_reg} < COL_LIMIT);
    end

    always_comb
    begin
        if (!is_pixel)
        begin
            kind = KIND_PALETTE;
            mask = 8'd0;
            base = pos_reg[6:0];
        end
        else
        begin
            unique case (cfg.depth)
                DEPTH_MONO:
                begin
                    kind = KIND_MONO;
                    mask = row_ok ? mono_mask : 8'd0;
                    base = {pos_reg[3:0], 3'b000};
                end
                DEPTH_INDEX8:
                begin
                    kind = KIND_INDEX;
                    mask = {7'd0, row_ok && idx_ok};
                    base = pos_reg[6:0];
                end
                default:
                begin
                    kind = KIND_COLOR;
                    mask = {7'd0, row_ok && (phase_reg == 2'd2) && col3_ok};
                    base = col3_reg[6:0];
                end
            endcase
        end
    end

    assign r_op = is_pixel ? data_byte : red;
    assign g_op = is_pixel ? held_reg[15:8] : green;
    assign b_op = is_pixel ? held_reg[7:0] : blue;
    assign sum  = 18'(r_op) * LUMA_R + 18'(g_op) * LUMA_G + 18'(b_op) * LUMA_B;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            srow_reg  <= '0;
            held_reg  <= '0;
            phase_reg <= '0;
            col3_reg  <= '0;
        end
        else if (accept && is_pixel)
        begin
            if (is_color && (phase_reg == 2'd0))
                held_reg[7:0] <= data_byte;
            if (is_color && (phase_reg == 2'd1))
                held_reg[15:8] <= data_byte;
            if (row_end)
            begin
                pos_reg   <= '0;
                phase_reg <= '0;
                col3_reg  <= '0;
                srow_reg  <= srow_wrap ? 12'd0 : srow_inc[11:0];
            end
            else
            begin
                pos_reg <= pos_inc[13:0];
                if (phase_reg == 2'd2)
                begin
                    phase_reg <= 2'd0;
                    col3_reg  <= col3_reg + 12'd1;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

    // advance the three stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign prod        = 37'(s0_sum_reg) * LUMA_RECIP;
    assign s1_in_range = ({1'b0, s1_index_reg} < PAL_LIMIT);
    assign s1_addr     = s1_index_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_kind_reg  <= kind;
            s0_sum_reg   <= sum;
            s0_index_reg <= is_pixel ? data_byte : palette_index;
            s0_mask_reg  <= mask;
            s0_base_reg  <= base;
            s0_row_reg   <= d_row[5:0];

            s1_kind_reg  <= s0_kind_reg;
            s1_luma_reg  <= prod[LUMA_SHIFT+7:LUMA_SHIFT];
            s1_index_reg <= s0_index_reg;
            s1_mask_reg  <= s0_mask_reg;
            s1_base_reg  <= s0_base_reg;
            s1_row_reg   <= s0_row_reg;

            s2_kind_reg     <= s1_kind_reg;
            s2_luma_reg     <= s1_luma_reg;
            s2_in_range_reg <= s1_in_range;
            s2_index_reg    <= s1_index_reg;
            s2_mask_reg     <= s1_mask_reg;
            s2_base_reg     <= s1_base_reg;
            s2_row_reg      <= s1_row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            if ((s1_kind_reg == KIND_PALETTE) && s1_in_range)
                luma_mem[s1_addr] <= s1_luma_reg;
            if (s1_kind_reg == KIND_INDEX)
                s2_rd_reg <= luma_mem[s1_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && (s1_kind_reg == KIND_PALETTE))
        begin
            if (s1_index_reg == 8'd0)
                luma0_reg <= s1_luma_reg;
            if (s1_index_reg == 8'd1)
                luma1_reg <= s1_luma_reg;
        end
    end

    assign lit0     = (luma0_reg > cfg.threshold);
    assign lit1     = (luma1_reg > cfg.threshold);
    assign idx_luma = s2_in_range_reg ? s2_rd_reg : 8'd0;

    always_comb
    begin
        job.mask = s2_mask_reg;
        job.base = s2_base_reg;
        job.row  = s2_row_reg;
        job.lit  = 8'd0;
        unique case (s2_kind_reg)
            KIND_MONO:
            begin
                for (int k = 0; k < 8; k++)
                    job.lit[k] = s2_index_reg[7-k] ? lit1 : lit0;
            end
            KIND_INDEX: job.lit = {7'd0, idx_luma > cfg.threshold};
            KIND_COLOR: job.lit = {7'd0, s2_luma_reg > cfg.threshold};
            default:    job.lit = 8'd0;
        endcase
    end

    assign job_push = need && !queue_full;

endmodule

FILE: rtl/core/bptm_queue.sv
module bptm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bptm_pkg::job_t  push_job,
    output logic            full,
    output logic            head_valid,
    output bptm_pkg::job_t  head_job,
    input  logic            pop
);
    import bptm_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PW:0] COUNT_FULL = (PW+1)'(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_pop;

    assign full       = (count_reg == COUNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/core/bptm_back.sv
module bptm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  bptm_pkg::job_t  head_job,
    output logic            pop,
    output logic            pixel_valid,
    input  logic            pixel_ready,
    output logic [6:0]      pixel_x,
    output logic [5:0]      pixel_y,
    output logic            lit,
    output logic            last
);
    import bptm_pkg::*;

    logic       started_reg;
    logic [7:0] rem_reg;
    logic       out_valid_reg;
    logic [6:0] out_x_reg;
    logic [5:0] out_y_reg;
    logic       out_lit_reg;
    logic       out_last_reg;

    logic [7:0] eff;
    logic [2:0] sel;
    logic [7:0] rest;
    logic       can_load;
    logic       emit;

    assign eff      = started_reg ? rem_reg : head_job.mask;
    assign can_load = !out_valid_reg || pixel_ready;
    assign emit     = head_valid && can_load;

    always_comb
    begin
        sel = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (eff[k])
                sel = 3'(k);
        end
        rest      = eff;
        rest[sel] = 1'b0;
    end

    assign pop = emit && (rest == 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
            started_reg   <= (rest != 8'd0);
        end
        else if (pixel_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rem_reg      <= rest;
            out_x_reg    <= head_job.base + 7'(sel);
            out_y_reg    <= head_job.row;
            out_lit_reg  <= head_job.lit[sel];
            out_last_reg <= (rest == 8'd0);
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign lit         = out_lit_reg;
    assign last        = out_last_reg;

endmodule

FILE: rtl/core/bmp_pixel_to_mono_threshold.sv
// channel  handshake              word
// item     item_valid/item_ready  operation, palette_index, red, green, blue, data_byte
// pixel    pixel_valid/pixel_ready pixel_x, pixel_y, lit, last
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item word per cycle enters unless the front stalls; a 1 bpp byte gives up to eight
// pixel words, sent one per cycle while pixel_ready is high, and new bytes enter while the
// queue has room. Pixels pass three front stages, the queue and an output register.
// The front stalls only when the four-entry job queue is full; cfg is always ready.
// rst_n clears the stream position, pipeline and queue; the luma table holds no reset.
module bmp_pixel_to_mono_threshold #(
    parameter int unsigned SCREEN_COLUMNS  = bptm_pkg::SCREEN_COLUMNS_DEFAULT,
    parameter int unsigned SCREEN_ROWS     = bptm_pkg::SCREEN_ROWS_DEFAULT,
    parameter int unsigned PALETTE_ENTRIES = bptm_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        operation,
    input  logic [7:0]  palette_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  data_byte,
    output logic        pixel_valid,
    input  logic        pixel_ready,
    output logic [6:0]  pixel_x,
    output logic [5:0]  pixel_y,
    output logic        lit,
    output logic        last
);
    import bptm_pkg::*;

    cfg_t cfg_reg;
    job_t push_job;
    job_t head_job;
    logic job_push;
    logic queue_full;
    logic head_valid;
    logic pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth     <= DEPTH_RESET;
            cfg_reg.width     <= WIDTH_RESET;
            cfg_reg.height    <= HEIGHT_RESET;
            cfg_reg.bottom_up <= BOTTOM_UP_RESET;
            cfg_reg.flip      <= FLIP_RESET;
            cfg_reg.threshold <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEPTH:     cfg_reg.depth     <= cfg_data[1:0];
                REG_WIDTH:     cfg_reg.width     <= cfg_data;
                REG_HEIGHT:    cfg_reg.height    <= cfg_data;
                REG_BOTTOM_UP: cfg_reg.bottom_up <= cfg_data[0];
                REG_FLIP:      cfg_reg.flip      <= cfg_data[0];
                REG_THRESHOLD: cfg_reg.threshold <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    bptm_front #(
        .SCREEN_COLUMNS  (SCREEN_COLUMNS),
        .SCREEN_ROWS     (SCREEN_ROWS),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .data_byte     (data_byte),
        .job           (push_job),
        .job_push      (job_push),
        .queue_full    (queue_full)
    );

    bptm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    bptm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .lit         (lit),
        .last        (last)
    );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bptm_pkg::*;

    localparam logic [1:0] DEPTH_SPARE = 2'd3;
    localparam logic [2:0] REG_SPARE6  = 3'd6;
    localparam logic [2:0] REG_SPARE7  = 3'd7;
    localparam int unsigned SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [6:0] x;
        logic [5:0] y;
        logic       lit;
        logic       last;
    } pixel_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        operation = 1'b0;
    logic [7:0]  palette_index = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [7:0]  data_byte = '0;
    logic        pixel_valid;
    logic        pixel_ready = 1'b0;
    logic [6:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic        lit;
    logic        last;

    // shadow of the block's registers and stream position
    logic [1:0]  cfg_depth = DEPTH_RESET;
    logic [11:0] cfg_width = WIDTH_RESET;
    logic [11:0] cfg_height = HEIGHT_RESET;
    logic        cfg_bottom_up = BOTTOM_UP_RESET;
    logic        cfg_flip = FLIP_RESET;
    logic [7:0]  cfg_threshold = THRESHOLD_RESET;
    logic [7:0]  luma_mem [256];
    bit          pal_loaded [256];
    int          pal_list [$];
    logic [13:0] byte_pos = '0;
    logic [11:0] row_pos = '0;
    logic [15:0] held_bgr = '0;

    pixel_word_t pixel_expect_q [$];
    pixel_word_t pixel_want;
    int          mismatches = 0;
    int          items_sent = 0;
    bit          quiet = 1'b0;

    always #4 clk = ~clk;

    bmp_pixel_to_mono_threshold i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .data_byte     (data_byte),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .lit           (lit),
        .last          (last)
    );

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned luma_of(input int unsigned rc, gc, bc);
        return (rc * 299 + gc * 587 + bc * 114) / 1000;
    endfunction

    function automatic pixel_word_t make_pixel(input int unsigned col, row, luma);
        pixel_word_t p;
        p.x    = col[6:0];
        p.y    = row[5:0];
        p.lit  = (luma > cfg_threshold);
        p.last = 1'b0;
        return p;
    endfunction

    function automatic void store_palette(input logic [7:0] idx, rc, gc, bc);
        luma_mem[idx] = 8'(luma_of(rc, gc, bc));
        if (!pal_loaded[idx])
        begin
            pal_loaded[idx] = 1'b1;
            pal_list.push_back(idx);
        end
    endfunction

    function automatic void predict_pixel_byte(input logic [7:0] data);
        int unsigned bpp, row_bytes, w, h, pos, r, d, col;
        bit          row_ok;
        int          n;
        pixel_word_t found [8];
        bpp = (cfg_depth == DEPTH_MONO) ? 1 : (cfg_depth == DEPTH_INDEX8) ? 8 : 24;
        w = cfg_width;
        h = cfg_height;
        row_bytes = ((w * bpp + 31) / 32) * 4;
        pos = byte_pos;
        row_ok = 1'b0;
        r = 0;
        d = 0;
        n = 0;
        if (row_pos < h)
        begin
            r = cfg_bottom_up ? h - 1 - row_pos : row_pos;
            d = cfg_flip ? h - 1 - r : r;
            row_ok = (r < SCREEN_ROWS_DEFAULT) && (d < SCREEN_ROWS_DEFAULT);
        end
        if (bpp == 1)
        begin
            for (int k = 0; k < 8; k++)
            begin
                col = pos * 8 + k;
                if (row_ok && col < w && col < SCREEN_COLUMNS_DEFAULT)
                begin
                    found[n] = make_pixel(col, d, luma_mem[data[7 - k]]);
                    n++;
                end
            end
        end
        else if (bpp == 8)
        begin
            col = pos;
            if (row_ok && col < w && col < SCREEN_COLUMNS_DEFAULT)
            begin
                found[0] = make_pixel(col, d, luma_mem[data]);
                n = 1;
            end
        end
        else
        begin
            col = pos / 3;
            if (pos % 3 == 0)
                held_bgr[7:0] = data;
            else if (pos % 3 == 1)
                held_bgr[15:8] = data;
            else if (row_ok && col < w && col < SCREEN_COLUMNS_DEFAULT)
            begin
                found[0] = make_pixel(col, d, luma_of(data, held_bgr[15:8], held_bgr[7:0]));
                n = 1;
            end
        end
        // advance to the next byte, wrapping rows and the frame
        if (pos + 1 >= row_bytes)
        begin
            byte_pos = '0;
            if (row_pos + 1 >= h)
                row_pos = '0;
            else
                row_pos = 12'(row_pos + 1);
        end
        else
            byte_pos = 14'(pos + 1);
        for (int i = 0; i < n; i++)
        begin
            found[i].last = (i == n - 1);
            pixel_expect_q.push_back(found[i]);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // hold valid after acceptance; the next word or settle drops it
    task automatic send_item(input logic op, input logic [7:0] idx, rc, gc, bc, data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (op == OP_PALETTE)
            store_palette(idx, rc, gc, bc);
        else
            predict_pixel_byte(data);
        item_valid    <= 1'b1;
        operation     <= op;
        palette_index <= idx;
        red           <= rc;
        green         <= gc;
        blue          <= bc;
        data_byte     <= data;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_palette(input logic [7:0] idx, rc, gc, bc);
        send_item(OP_PALETTE, idx, rc, gc, bc, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
        case (idx)
            REG_DEPTH:     cfg_depth = value[1:0];
            REG_WIDTH:     cfg_width = value;
            REG_HEIGHT:    cfg_height = value;
            REG_BOTTOM_UP: cfg_bottom_up = value[0];
            REG_FLIP:      cfg_flip = value[0];
            REG_THRESHOLD: cfg_threshold = value[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // noise in the unused upper bits of the narrow registers
    task automatic set_geometry(input logic [1:0] depth, input logic [11:0] width, height,
                                input logic bottom_up, flip, input logic [7:0] threshold,
                                input bit with_spare);
        logic [11:0] noise;
        settle();
        noise = 12'($urandom);
        write_reg(REG_DEPTH, {noise[11:2], depth});
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        noise = 12'($urandom);
        write_reg(REG_BOTTOM_UP, {noise[11:1], bottom_up});
        noise = 12'($urandom);
        write_reg(REG_FLIP, {noise[11:1], flip});
        noise = 12'($urandom);
        write_reg(REG_THRESHOLD, {noise[11:8], threshold});
        if (with_spare)
        begin
            write_reg(REG_SPARE6, 12'($urandom));
            write_reg(REG_SPARE7, 12'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_palette_extremes();
        load_palette(8'd0, 8'd0, 8'd0, 8'd0);
        load_palette(8'd1, 8'd255, 8'd255, 8'd255);
        load_palette(8'd255, 8'd255, 8'd0, 8'd0);
        load_palette(8'd128, 8'd0, 8'd255, 8'd0);
        load_palette(8'd127, 8'd0, 8'd0, 8'd255);
    endtask

    task automatic test_mono_rows();
        set_geometry(DEPTH_MONO, 12'd10, 12'd3, 1'b1, 1'b0, 8'd128, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h40);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_index8_flip();
        set_geometry(DEPTH_INDEX8, 12'd3, 12'd2, 1'b0, 1'b1, 8'd0, 1'b0);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd128);
        send_byte(8'd1);
    endtask

    task automatic test_bgr24();
        set_geometry(DEPTH_BGR24, 12'd1, 12'd2, 1'b1, 1'b1, 8'd254, 1'b0);
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd0);
        set_geometry(DEPTH_SPARE, 12'd2, 12'd1, 1'b0, 1'b0, 8'd255, 1'b0);
        send_byte(8'd10);
        send_byte(8'd20);
        send_byte(8'd30);
        send_byte(8'd255);
    endtask

    task automatic test_empty_geometry();
        set_geometry(DEPTH_MONO, 12'd0, 12'd0, 1'b0, 1'b0, 8'd128, 1'b1);
        send_byte(8'hA5);
        send_byte(8'h5A);
    endtask

    task automatic test_random_images();
        int          burst, roll;
        logic [1:0]  depth;
        logic [11:0] width, height;
        logic [7:0]  threshold, data, idx, rc, gc, bc;
        while (items_sent < 380)
        begin
            roll = $urandom_range(0, 9);
            depth = (roll == 0) ? DEPTH_SPARE : (roll < 4) ? DEPTH_MONO :
                    (roll < 7) ? DEPTH_INDEX8 : DEPTH_BGR24;
            roll = $urandom_range(0, 19);
            width = (roll == 0) ? 12'd0 : (roll == 1) ? 12'd4095 :
                    (roll == 2) ? 12'($urandom_range(161, 4095)) :
                    12'($urandom_range(1, 160));
            roll = $urandom_range(0, 19);
            height = (roll == 0) ? 12'd0 : (roll == 1) ? 12'd4095 :
                     (roll == 2) ? 12'($urandom_range(65, 4095)) :
                     12'($urandom_range(1, 80));
            roll = $urandom_range(0, 9);
            threshold = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom);
            set_geometry(depth, width, height, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), threshold, $urandom_range(0, 4) == 0);
            quiet = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(12, 40);
            repeat (burst)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    idx = 8'($urandom);
                    rc = 8'($urandom);
                    gc = 8'($urandom);
                    bc = 8'($urandom);
                    if ($urandom_range(0, 6) == 0)
                    begin
                        rc = rc[0] ? 8'hFF : 8'h00;
                        gc = gc[0] ? 8'hFF : 8'h00;
                        bc = bc[0] ? 8'hFF : 8'h00;
                    end
                    load_palette(idx, rc, gc, bc);
                end
                else
                begin
                    // keep indexed reads on loaded palette entries
                    data = 8'($urandom);
                    if (cfg_depth == DEPTH_INDEX8 && !pal_loaded[data])
                        data = 8'(pal_list[$urandom_range(0, pal_list.size() - 1)]);
                    send_byte(data);
                end
            end
            quiet = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && pixel_ready)
        begin
            if (pixel_expect_q.size() == 0)
                report_mismatch("unexpected pixel, x", pixel_x, -1);
            else
            begin
                pixel_want = pixel_expect_q.pop_front();
                if (pixel_x !== pixel_want.x)
                    report_mismatch("pixel_x", pixel_x, pixel_want.x);
                if (pixel_y !== pixel_want.y)
                    report_mismatch("pixel_y", pixel_y, pixel_want.y);
                if (lit !== pixel_want.lit)
                    report_mismatch("lit", lit, pixel_want.lit);
                if (last !== pixel_want.last)
                    report_mismatch("last", last, pixel_want.last);
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                pixel_ready <= 1'b0;
                stall--;
            end
            else
            begin
                pixel_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_palette_extremes();
        test_mono_rows();
        test_index8_flip();
        test_bgr24();
        test_empty_geometry();
        test_random_images();
        settle();
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
